// File: design/flpte_pkg.sv
// shared widths, action codes and status codes of the page table engine
package flpte_pkg;

	localparam int ACTION_W = 2;
	localparam int VIRT_W   = 48;
	localparam int PHYS_W   = 52;
	localparam int FLAGS_W  = 64;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 64;
	localparam int IDX_W    = 9;
	localparam int PFN_W    = 40;

	localparam logic [ACTION_W-1:0] ACT_TRANSLATE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_MAP       = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_UNMAP     = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_RSVD      = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_TABLE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_PRESENCE   = 2'd3;

endpackage

// File: design/flpte_if.sv
// request, response and configuration channels of the page table engine
interface flpte_req_if import flpte_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [VIRT_W-1:0]   virt;
	logic [PHYS_W-1:0]   phys;
	logic [FLAGS_W-1:0]  entry_flags;

	modport source (output valid, action, virt, phys, entry_flags, input ready);
	modport sink   (input valid, action, virt, phys, entry_flags, output ready);
endinterface

interface flpte_rsp_if import flpte_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PHYS_W-1:0]   translated_addr;

	modport source (output valid, status, translated_addr, input ready);
	modport sink   (input valid, status, translated_addr, output ready);
endinterface

interface flpte_cfg_if import flpte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PHYS_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// File: design/four_level_page_table_engine.sv
// four-level page table engine: walk, map and unmap over an on-chip table pool
//
// The block holds TABLE_FRAMES page tables of 512 entries in one ram; frame 0 is
// the top-level table and frame f sits at root_table_base + f * 4096. After reset
// the ram is swept to zero, one entry a cycle, over TABLE_FRAMES * 512 entries
// (32768 at the default); no request is taken during the sweep, configuration
// writes are. An item that walks all four levels is accepted, then makes four
// dependent table reads, each a read issue and a check of the registered read
// data, and then hands over the response. A misaligned item, an unused action or
// a walk that stops at a missing table finishes sooner. New tables and the leaf
// update are written in the check state of their level, so they need no state
// of their own. The response sits in an output register, so the next request
// is taken while the previous response still waits.
module four_level_page_table_engine import flpte_pkg::*; #(
	parameter int TABLE_FRAMES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	flpte_req_if.sink   req,
	flpte_rsp_if.source rsp,
	flpte_cfg_if.sink   cfg
);

	localparam int DEPTH = TABLE_FRAMES * 512;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(TABLE_FRAMES);
	localparam int NW    = $clog2(TABLE_FRAMES + 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [PHYS_W-1:0]   base_q;
	logic [ACTION_W-1:0] act_q;
	logic [VIRT_W-1:0]   virt_q;
	logic [PHYS_W-1:0]   phys_q;
	logic [FLAGS_W-1:0]  flags_q;
	logic [1:0]          lvl_q;
	logic [FW-1:0]       frame_q;
	logic [NW-1:0]       nff_q;
	logic [STATUS_W-1:0] status_q;
	logic [PHYS_W-1:0]   res_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [PHYS_W-1:0]   out_addr_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic                ram_re;
	logic [ENTRY_W-1:0]  ram_rdata;

	logic [IDX_W-1:0]    idx;
	logic [AW-1:0]       entry_addr;
	logic                present;
	logic                is_leaf;
	logic                pool_full;
	logic [PFN_W-1:0]    e_off;
	logic                in_pool;
	logic [PFN_W-1:0]    new_pfn;
	logic                req_fire;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.translated_addr = out_addr_q;

	always_comb begin
		case (lvl_q)
			2'd0:    idx = virt_q[47:39];
			2'd1:    idx = virt_q[38:30];
			2'd2:    idx = virt_q[29:21];
			default: idx = virt_q[20:12];
		endcase
	end

	assign entry_addr = {frame_q, idx};
	assign present    = ram_rdata[0];
	assign is_leaf    = (lvl_q == 2'd3);
	assign pool_full  = (nff_q == NW'(TABLE_FRAMES));
	// pool frame number of a present entry under the current base
	assign e_off      = ram_rdata[51:12] - base_q[51:12];
	assign in_pool    = (e_off < PFN_W'(TABLE_FRAMES));
	assign new_pfn    = base_q[51:12] + PFN_W'(nff_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = entry_addr;
		ram_wdata = '0;
		ram_re    = (state_q == S_READ);
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_CHECK: begin
				if (!is_leaf) begin
					if (!present && act_q == ACT_MAP && !pool_full) begin
						ram_we    = 1'b1;
						ram_wdata = {12'b0, new_pfn, 7'b0, flags_q[4:1], 1'b1};
					end
				end else if (act_q == ACT_MAP) begin
					if (!present) begin
						// flag bits are not masked off the address field
						ram_we    = 1'b1;
						ram_wdata = {flags_q[63:52], phys_q[51:12] | flags_q[51:12],
							flags_q[11:8], 1'b0, flags_q[6:1], 1'b1};
					end
				end else if (act_q == ACT_UNMAP) begin
					ram_we = present;
				end
			end
			default: begin
			end
		endcase
	end

	flpte_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_pool (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (entry_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			base_q       <= '0;
			act_q        <= ACT_TRANSLATE;
			virt_q       <= '0;
			phys_q       <= '0;
			flags_q      <= '0;
			lvl_q        <= '0;
			frame_q      <= '0;
			nff_q        <= NW'(1);
			status_q     <= ST_OK;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_addr_q   <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				base_q <= cfg.data;
			end
			// in S_DONE the output register is reloaded below instead
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						act_q    <= req.action;
						virt_q   <= req.virt;
						phys_q   <= req.phys;
						flags_q  <= req.entry_flags;
						lvl_q    <= '0;
						frame_q  <= '0;
						res_q    <= '0;
						status_q <= ST_OK;
						case (req.action)
							ACT_TRANSLATE: state_q <= S_READ;
							ACT_MAP: begin
								if (req.virt[11:0] != '0 || req.phys[11:0] != '0) begin
									status_q <= ST_MISALIGNED;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							ACT_UNMAP: begin
								if (req.virt[11:0] != '0) begin
									status_q <= ST_MISALIGNED;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!is_leaf) begin
						if (present) begin
							if (in_pool) begin
								frame_q <= e_off[FW-1:0];
								lvl_q   <= lvl_q + 2'd1;
								state_q <= S_READ;
							end else begin
								status_q <= ST_NO_TABLE;
								state_q  <= S_DONE;
							end
						end else if (act_q == ACT_MAP && !pool_full) begin
							frame_q <= nff_q[FW-1:0];
							nff_q   <= nff_q + NW'(1);
							lvl_q   <= lvl_q + 2'd1;
							state_q <= S_READ;
						end else begin
							status_q <= ST_NO_TABLE;
							state_q  <= S_DONE;
						end
					end else begin
						state_q <= S_DONE;
						case (act_q)
							ACT_TRANSLATE: begin
								if (present) begin
									res_q <= {ram_rdata[51:12], virt_q[11:0]};
								end else begin
									status_q <= ST_PRESENCE;
								end
							end
							ACT_MAP: begin
								if (present) begin
									status_q <= ST_PRESENCE;
								end
							end
							default: begin
								if (!present) begin
									status_q <= ST_PRESENCE;
								end
							end
						endcase
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_addr_q   <= res_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/flpte_ram.sv
// generic single-clock ram with one write port and one registered read port
module flpte_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
